### rtl/linked_list_queue_manager_unit_macros.svh
// Assertion macros for the linked list queue manager.
// Included by the modules that carry checks; no other dependencies.
`ifndef LINKED_LIST_QUEUE_MANAGER_UNIT_MACROS_SVH
`define LINKED_LIST_QUEUE_MANAGER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LLQ_ASSERT_IMP(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("llq check failed");
`define LLQ_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("llq check failed");
`else
`define LLQ_ASSERT_IMP(label, ck, rn, ante, cons)
`define LLQ_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

### rtl/llq_pkg.sv
// Shared sizes, codes and types of the linked list queue manager.
// Stand-alone; used by the top level.
package llq_pkg;

  localparam int NUM_NODES  = 64;
  localparam int NUM_QUEUES = 8;
  localparam int NODE_W     = $clog2(NUM_NODES);
  localparam int QUEUE_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CNT_W      = $clog2(NUM_NODES + 1);

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_QUEUED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_NOT_IN = 2'd3
  } status_t;

  // One entry of the forward link memory: owner queue and successor.
  typedef struct packed {
    logic [QUEUE_W-1:0] owner;
    logic [NODE_W-1:0]  next;
  } fwd_entry_t;

  localparam int FWD_W = $bits(fwd_entry_t);

endpackage

### rtl/linked_list_queue_manager_unit.sv
// Top level of the linked list queue manager: control sequencer, queue tables,
// result register. Uses llq_pkg, llq_ram and the assertion macro header.
//
// Keeps eight circular doubly linked queues over a pool of 64 nodes. Each input
// beat appends a node at a queue's tail or removes a node from a queue, and
// yields one result beat with status, length, head and a non-empty flag.
// Successor links and owner tags sit in one RAM, predecessor links in another;
// both have a registered read. A beat steps through accept, link read and
// update, and result; an append to a non-empty queue adds a second write step,
// since it writes two entries of each link RAM through its single write port. A
// finished result waits in the output register while the next beat is taken.
// No clearing pass follows reset: linked bits and queue lengths reset in flops.
`include "linked_list_queue_manager_unit_macros.svh"

module linked_list_queue_manager_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [0] operation, [3:1] queue_id, [9:4] node_id
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [1:0] status, [8:2] queue_length,
                                  // [14:9] head_node, [15] queue_nonempty
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_APP2 = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  localparam int NN = llq_pkg::NUM_NODES;
  localparam int NQ = llq_pkg::NUM_QUEUES;
  localparam int NW = llq_pkg::NODE_W;
  localparam int QW = llq_pkg::QUEUE_W;
  localparam int CW = llq_pkg::CNT_W;

  state_t             state_r, state_nxt;
  llq_pkg::op_t       op_r, op_nxt;
  logic [QW-1:0]      q_r, q_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  llq_pkg::status_t   status_r, status_nxt;
  logic [NN-1:0]      linked_r, linked_nxt;
  logic [CW-1:0]      count_r [NQ];
  logic [CW-1:0]      count_nxt [NQ];
  logic [NW-1:0]      head_r [NQ];
  logic [NW-1:0]      head_nxt [NQ];
  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        out_data_r, out_data_nxt;

  llq_pkg::op_t       in_op;
  logic [QW-1:0]      in_q;
  logic [NW-1:0]      in_n;
  logic               in_fire;

  logic               a_we, b_we;
  logic [NW-1:0]      a_waddr, a_raddr, b_waddr, b_raddr;
  llq_pkg::fwd_entry_t a_wdata, a_rdata;
  logic [NW-1:0]      b_wdata, b_rdata;

  logic [CW-1:0]      cur_cnt;
  logic [CW-1:0]      res_len;
  logic [NW-1:0]      res_head;

  assign in_op   = llq_pkg::op_t'(in_tdata[0]);
  assign in_q    = in_tdata[1 +: QW];
  assign in_n    = in_tdata[4 +: NW];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire = in_tvalid && in_tready;

  assign cur_cnt  = count_r[q_r];
  assign res_len  = count_r[q_r];
  assign res_head = (res_len != '0) ? head_r[q_r] : '0;

  llq_ram #(.WIDTH(llq_pkg::FWD_W), .DEPTH(NN)) u_fwd_ram (
    .clk     (clk),
    .wr_en   (a_we),
    .wr_addr (a_waddr),
    .wr_data (a_wdata),
    .rd_addr (a_raddr),
    .rd_data (a_rdata)
  );

  llq_ram #(.WIDTH(NW), .DEPTH(NN)) u_bwd_ram (
    .clk     (clk),
    .wr_en   (b_we),
    .wr_addr (b_waddr),
    .wr_data (b_wdata),
    .rd_addr (b_raddr),
    .rd_data (b_rdata)
  );

  // The link RAMs read every cycle, but only data read at accept is used, after
  // all writes of the previous beat, so no used read overlaps a write of its entry.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    q_nxt         = q_r;
    n_nxt         = n_r;
    status_nxt    = status_r;
    linked_nxt    = linked_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    a_we          = 1'b0;
    a_waddr       = n_r;
    a_wdata       = '{owner: q_r, next: n_r};
    b_we          = 1'b0;
    b_waddr       = n_r;
    b_wdata       = n_r;
    a_raddr       = in_n;
    b_raddr       = (in_op == llq_pkg::OP_APPEND) ? head_r[in_q] : in_n;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt    = in_op;
          q_nxt     = in_q;
          n_nxt     = in_n;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        if (op_r == llq_pkg::OP_APPEND) begin
          if (linked_r[n_r]) begin
            status_nxt = llq_pkg::ST_QUEUED;
          end else begin
            status_nxt     = llq_pkg::ST_OK;
            linked_nxt[n_r] = 1'b1;
            count_nxt[q_r] = cur_cnt + CW'(1);
            a_we           = 1'b1;
            b_we           = 1'b1;
            if (cur_cnt == '0) begin
              // Single node links to itself.
              head_nxt[q_r] = n_r;
            end else begin
              // Old tail points forward to the new node.
              a_waddr   = b_rdata;
              b_wdata   = b_rdata;
              state_nxt = S_APP2;
            end
          end
        end else begin
          if (cur_cnt == '0) begin
            status_nxt = llq_pkg::ST_EMPTY;
          end else if (!linked_r[n_r] || (a_rdata.owner != q_r)) begin
            status_nxt = llq_pkg::ST_NOT_IN;
          end else begin
            status_nxt      = llq_pkg::ST_OK;
            linked_nxt[n_r] = 1'b0;
            count_nxt[q_r]  = cur_cnt - CW'(1);
            a_we            = 1'b1;
            a_waddr         = b_rdata;
            a_wdata         = '{owner: q_r, next: a_rdata.next};
            b_we            = 1'b1;
            b_waddr         = a_rdata.next;
            b_wdata         = b_rdata;
            if (head_r[q_r] == n_r) begin
              head_nxt[q_r] = (a_rdata.next == n_r) ? '0 : a_rdata.next;
            end
          end
        end
      end
      S_APP2: begin
        // Close the ring: new node points to head, head points back.
        a_we      = 1'b1;
        a_waddr   = n_r;
        a_wdata   = '{owner: q_r, next: head_r[q_r]};
        b_we      = 1'b1;
        b_waddr   = head_r[q_r];
        b_wdata   = n_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hold until the result register is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {res_len != '0, res_head, res_len, status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      linked_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NQ; i++) begin
        count_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      linked_r    <= linked_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
    op_r       <= op_nxt;
    q_r        <= q_nxt;
    n_r        <= n_nxt;
    status_r   <= status_nxt;
    head_r     <= head_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `LLQ_ASSERT_NEXT(a_app_links, clk, rst_n, (state_r == S_EXEC) && (op_r == llq_pkg::OP_APPEND) && (status_nxt == llq_pkg::ST_OK), linked_r[n_r])
  `LLQ_ASSERT_NEXT(a_rem_unlinks, clk, rst_n, (state_r == S_EXEC) && (op_r == llq_pkg::OP_REMOVE) && (status_nxt == llq_pkg::ST_OK), !linked_r[n_r])
  `LLQ_ASSERT_NEXT(a_done_holds, clk, rst_n, (state_r == S_DONE) && out_valid_r && !out_tready, state_r == S_DONE)

endmodule

### rtl/llq_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module llq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
